[rtl/assert_macros.svh]
// Assertion helpers used by sst_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define SST_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/sst_pkg.sv]
`timescale 1ns / 1ps

package sst_pkg;

   localparam int IDX_W       = 11;
   localparam int AMT_W       = 32;
   localparam int SUM_W       = 32;
   localparam int REQ_TDATA_W = 56;

   // func codes
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // one input word, unpacked
   typedef struct packed {
      logic                    func;
      logic [IDX_W-1:0]        first_index;
      logic [IDX_W-1:0]        end_index;
      logic signed [AMT_W-1:0] amount;
   } item_type;

   // finished query result offered to the output register
   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] sum;
   } result_type;

endpackage

[rtl/sst_mem.sv]
`timescale 1ns / 1ps

module sst_mem #(
   parameter int AW = 11,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   localparam int DEPTH = 1 << AW;

   logic [DW-1:0] ram_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         ram_ff[waddr] <= wdata;
      end
      rdata_ff <= ram_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/sst_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sst_ctrl #(
   parameter int LEAVES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sst_pkg::item_type      item,
   output logic                   ready,
   input  logic                   out_free,
   output sst_pkg::result_type    res,
   output logic                   mem_we,
   output logic [$clog2(LEAVES):0] mem_waddr,
   output logic [sst_pkg::SUM_W-1:0] mem_wdata,
   output logic [$clog2(LEAVES):0] mem_raddr,
   input  logic [sst_pkg::SUM_W-1:0] mem_rdata
);

   localparam int NW = $clog2(LEAVES) + 1;   // node address bits
   localparam int HW = NW + 1;               // range bound bits, holds 2*LEAVES
   localparam logic [31:0] LEAVES32 = 32'(LEAVES);

   typedef enum logic [6:0] {
      S_CLEAR    = 7'b0000001,
      S_IDLE     = 7'b0000010,
      S_UPD_LEAF = 7'b0000100,
      S_UPD_PAR  = 7'b0001000,
      S_QRY_LO   = 7'b0010000,
      S_QRY_HI   = 7'b0100000,
      S_QRY_OUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [NW-1:0] node_ff, node_in;
   logic [HW-1:0] lo_ff, lo_in;
   logic [HW-1:0] hi_ff, hi_in;
   logic          pend_ff, pend_in;
   logic [sst_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic [sst_pkg::SUM_W-1:0] val_ff, val_in;
   logic [sst_pkg::AMT_W-1:0] amount_ff, amount_in;

   logic [31:0] first32, end32, hi_clip32;
   logic [NW-1:0] start_node, parent;
   logic [HW-1:0] start_lo, start_hi, hi_dec;
   logic          upd_ok, qry_empty;
   logic [sst_pkg::SUM_W-1:0] add_a, add_b, sum;

   // decode of a new item
   assign first32    = 32'(item.first_index);
   assign end32      = 32'(item.end_index);
   assign hi_clip32  = (end32 > LEAVES32) ? LEAVES32 : end32;
   assign start_node = NW'(first32 + LEAVES32);
   assign start_lo   = HW'(first32 + LEAVES32);
   assign start_hi   = HW'(hi_clip32 + LEAVES32);
   assign upd_ok     = first32 < LEAVES32;
   assign qry_empty  = first32 >= hi_clip32;

   assign parent = node_ff >> 1;
   assign hi_dec = hi_ff - HW'(1);

   // the shared adder
   always_comb begin
      add_a = acc_ff;
      add_b = mem_rdata;
      if (state_ff == S_UPD_LEAF) begin
         add_a = mem_rdata;
         add_b = amount_ff;
      end else if (state_ff == S_UPD_PAR) begin
         add_a = val_ff;
      end
   end
   assign sum = add_a + add_b;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      node_in   = node_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      pend_in   = 1'b0;
      val_in    = val_ff;
      amount_in = amount_ff;
      acc_in    = pend_ff ? sum : acc_ff;
      mem_we    = 1'b0;
      mem_waddr = node_ff;
      mem_wdata = sum;
      mem_raddr = start_node;
      res.valid = 1'b0;
      res.sum   = acc_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + NW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (item.func == sst_pkg::FUNC_QUERY) begin
                  acc_in = '0;
                  lo_in  = start_lo;
                  hi_in  = start_hi;
                  state_in = qry_empty ? S_QRY_OUT : S_QRY_LO;
               end else if (upd_ok) begin
                  node_in   = start_node;
                  amount_in = item.amount;
                  state_in  = S_UPD_LEAF;
               end
            end
         end
         S_UPD_LEAF: begin
            // leaf plus amount; fetch the sibling
            mem_we    = 1'b1;
            mem_waddr = node_ff;
            val_in    = sum;
            mem_raddr = node_ff ^ NW'(1);
            state_in  = S_UPD_PAR;
         end
         S_UPD_PAR: begin
            // parent = fresh child + sibling; fetch the parent's sibling
            mem_we    = 1'b1;
            mem_waddr = parent;
            val_in    = sum;
            node_in   = parent;
            mem_raddr = parent ^ NW'(1);
            if (parent == NW'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_QRY_LO: begin
            if (lo_ff >= hi_ff) begin
               state_in = S_QRY_OUT;
            end else begin
               if (lo_ff[0]) begin
                  mem_raddr = lo_ff[NW-1:0];
                  pend_in   = 1'b1;
                  lo_in     = lo_ff + HW'(1);
               end
               state_in = S_QRY_HI;
            end
         end
         S_QRY_HI: begin
            if (hi_ff[0]) begin
               mem_raddr = hi_dec[NW-1:0];
               pend_in   = 1'b1;
            end
            lo_in    = lo_ff >> 1;
            hi_in    = hi_ff >> 1;
            state_in = S_QRY_LO;
         end
         S_QRY_OUT: begin
            res.valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ready = (state_ff == S_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      node_ff   <= node_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      acc_ff    <= acc_in;
      val_ff    <= val_in;
      amount_ff <= amount_in;
   end

   `SST_ASSERT(a_range_ordered, clock, reset, state_ff == S_QRY_LO || state_ff == S_QRY_HI, lo_ff <= hi_ff)
   `SST_ASSERT(a_upd_below_root, clock, reset, state_ff == S_UPD_PAR, node_ff > NW'(1))
   `SST_ASSERT(a_no_pending_read, clock, reset, state_ff == S_IDLE || state_ff == S_QRY_OUT, !pend_ff)
   `SST_ASSERT_NEXT(a_clear_ends, clock, reset, state_ff == S_CLEAR && clr_ff == '1, state_ff == S_IDLE)

endmodule

[rtl/sum_segment_tree.sv]
`timescale 1ns / 1ps
// Point-update, range-sum tree over LEAVES 32-bit leaf counters (LEAVES a power of two).
// Input channel req_*: one word per item. req_tuser is func (0 add, 1 query).
// An add puts amount onto leaf first_index and rebuilds its ancestors; it gives no
// result, and an add with first_index >= LEAVES is dropped. A query returns one
// rsp_* word with the wrapped sum of leaves [first_index, end_index), end clipped to
// LEAVES, zero when the range is empty.
// Datapath: each item is worked through one memory (one write port, one registered
// read port) and one shared adder; req_tready is low while an item is in work.
// Reset: after reset deasserts a clearing pass writes all 2*LEAVES entries to zero
// before the first item is accepted.
// Stall: the result sits in an output register; the next item is accepted while it
// waits, and a following query holds its finished sum until rsp_tready frees it.

module sum_segment_tree #(
   parameter int LEAVES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [10:0] first_index, [21:11] end_index, [53:22] amount, [55:54] zero
   input  logic [sst_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] func
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] range_sum
   output logic [sst_pkg::SUM_W-1:0]         rsp_tdata
);

   localparam int NW = $clog2(LEAVES) + 1;

   sst_pkg::item_type   item;
   sst_pkg::result_type res;
   logic                ready, start, out_free;
   logic                mem_we;
   logic [NW-1:0]       mem_waddr, mem_raddr;
   logic [sst_pkg::SUM_W-1:0] mem_wdata, mem_rdata;
   logic                rsp_tvalid_ff;
   logic [sst_pkg::SUM_W-1:0] rsp_tdata_ff;

   // unpack the input word
   assign item.func        = req_tuser;
   assign item.first_index = req_tdata[10:0];
   assign item.end_index   = req_tdata[21:11];
   assign item.amount      = req_tdata[53:22];

   assign req_tready = ready;
   assign start      = req_tvalid && ready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   sst_ctrl #(
      .LEAVES(LEAVES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item),
      .ready     (ready),
      .out_free  (out_free),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   sst_mem #(
      .AW(NW),
      .DW(sst_pkg::SUM_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_tvalid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && out_free) begin
         rsp_tdata_ff <= res.sum;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
